// ----- src/bluc_pkg.sv -----
// Shared types, constants and mapping functions of the byte-level codec.
package bluc_pkg;

   // Direction register codes.
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // Most results one request can cause.
   localparam int MaxResults = 4;

   // Byte ranges that map to their own code point.
   localparam logic [7:0] PRINT_LO_A = 8'd33;
   localparam logic [7:0] PRINT_HI_A = 8'd126;
   localparam logic [7:0] PRINT_LO_B = 8'd161;
   localparam logic [7:0] PRINT_HI_B = 8'd172;
   localparam logic [7:0] PRINT_LO_C = 8'd174;

   // Ends of the shifted code point ranges.
   localparam logic [10:0] CP_CTRL_LO  = 11'd256;
   localparam logic [10:0] CP_CTRL_HI  = 11'd288;
   localparam logic [10:0] CP_HIGH_LO  = 11'd289;
   localparam logic [10:0] CP_HIGH_HI  = 11'd322;
   localparam logic [10:0] CP_SOFT_HY  = 11'd323;
   localparam logic [10:0] CP_HIGH_OFS = 11'd162;
   localparam logic [7:0]  BYTE_SOFT_HY = 8'd173;

   // Group of result bytes produced by one request.
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [2:0]                 count;
      logic                       eot;
   } grp_type;

   // Outcome of a two-byte character lookup.
   typedef struct packed {
      logic       hit;
      logic [7:0] value;
   } map_type;

   // True for bytes that stand for themselves.
   function automatic logic is_printable(input logic [7:0] b);
      return (b >= PRINT_LO_A && b <= PRINT_HI_A) ||
             (b >= PRINT_LO_B && b <= PRINT_HI_B) ||
             (b >= PRINT_LO_C);
   endfunction

   // Code point (nine bits) that stands for a raw byte.
   function automatic logic [8:0] byte_to_cp(input logic [7:0] b);
      logic [8:0] cp;
      if (is_printable(b)) begin
         cp = {1'b0, b};
      end else if (b < PRINT_LO_A) begin
         cp = {1'b1, b};
      end else if (b < PRINT_LO_B) begin
         cp = {1'b0, b} + CP_HIGH_OFS[8:0];
      end else begin
         cp = CP_SOFT_HY[8:0];
      end
      return cp;
   endfunction

   // Character length that a lead byte announces; invalid leads count as one.
   function automatic logic [2:0] lead_length(input logic [7:0] c);
      logic [2:0] len;
      if (c[7] == 1'b0) begin
         len = 3'd1;
      end else if (c[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (c[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (c[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd1;
      end
      return len;
   endfunction

   // Maps a two-byte character back to its raw byte when it is a mapped form.
   function automatic map_type map_two(input logic [7:0] c1, input logic [7:0] c2);
      logic [10:0] cp;
      logic [10:0] diff;
      map_type     r;
      cp      = {c1[4:0], c2[5:0]};
      diff    = cp - CP_HIGH_OFS;
      r.hit   = 1'b0;
      r.value = 8'd0;
      if (c2[7:6] == 2'b10) begin
         if ((cp >= {3'b000, PRINT_LO_B} && cp <= {3'b000, PRINT_HI_B}) ||
             (cp >= {3'b000, PRINT_LO_C} && cp < CP_CTRL_LO)) begin
            r.hit   = 1'b1;
            r.value = cp[7:0];
         end else if (cp >= CP_CTRL_LO && cp <= CP_CTRL_HI) begin
            r.hit   = 1'b1;
            r.value = cp[7:0];
         end else if (cp >= CP_HIGH_LO && cp <= CP_HIGH_HI) begin
            r.hit   = 1'b1;
            r.value = diff[7:0];
         end else if (cp == CP_SOFT_HY) begin
            r.hit   = 1'b1;
            r.value = BYTE_SOFT_HY;
         end
      end
      return r;
   endfunction

endpackage

// ----- src/bluc_char_unit.sv -----
// Direction register, partial character state and result group logic.
module bluc_char_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              advance,
   input  logic [7:0]        in_byte,
   input  logic              in_eot,
   output bluc_pkg::grp_type grp
);

   logic       dir_ff;
   logic [2:0] char_len_ff, char_len_in;
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic [7:0] held_ff [3];
   logic       held_we;
   logic [1:0] held_wr_idx;
   logic [8:0] cp;
   logic [2:0] lead;
   logic [2:0] n;
   bluc_pkg::map_type map;

   assign cp   = bluc_pkg::byte_to_cp(in_byte);
   assign lead = bluc_pkg::lead_length(in_byte);
   assign map  = bluc_pkg::map_two(held_ff[0], in_byte);
   assign n    = {1'b0, held_cnt_ff} + 3'd1;

   // Build the result group and the next character state for the current request.
   always_comb begin
      grp.eot     = in_eot;
      grp.count   = 3'd0;
      char_len_in = char_len_ff;
      held_cnt_in = held_cnt_ff;
      held_we     = 1'b0;
      held_wr_idx = held_cnt_ff;
      // Pass-through order: held bytes first, then the current byte.
      for (int i = 0; i < 3; i++) begin
         grp.bytes[i] = (i < int'(held_cnt_ff)) ? held_ff[i] : in_byte;
      end
      grp.bytes[3] = in_byte;

      if (dir_ff == bluc_pkg::DIR_ENCODE) begin
         if (cp[8:7] == 2'b00) begin
            grp.count    = 3'd1;
            grp.bytes[0] = cp[7:0];
         end else begin
            grp.count    = 3'd2;
            grp.bytes[0] = {5'b11000, cp[8:6]};
            grp.bytes[1] = {2'b10, cp[5:0]};
         end
         char_len_in = 3'd0;
         held_cnt_in = 2'd0;
      end else if (char_len_ff == 3'd0) begin
         if (lead == 3'd1 || in_eot) begin
            grp.count = 3'd1;
         end else begin
            held_we     = 1'b1;
            held_wr_idx = 2'd0;
            held_cnt_in = 2'd1;
            char_len_in = lead;
         end
      end else if (n >= char_len_ff) begin
         // Character complete: map it back or pass it through.
         if (n == 3'd2 && map.hit) begin
            grp.count    = 3'd1;
            grp.bytes[0] = map.value;
         end else begin
            grp.count = n;
         end
         char_len_in = 3'd0;
         held_cnt_in = 2'd0;
      end else if (in_eot) begin
         grp.count   = n;
         char_len_in = 3'd0;
         held_cnt_in = 2'd0;
      end else begin
         held_we     = 1'b1;
         held_cnt_in = n[1:0];
      end
   end

   // Control state; a register write drops any partial character.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff      <= bluc_pkg::DIR_ENCODE;
         char_len_ff <= 3'd0;
         held_cnt_ff <= 2'd0;
      end else if (csr_wr_en) begin
         dir_ff      <= csr_wr_data;
         char_len_ff <= 3'd0;
         held_cnt_ff <= 2'd0;
      end else if (advance) begin
         char_len_ff <= char_len_in;
         held_cnt_ff <= held_cnt_in;
      end
   end

   // Bytes of the partial character.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (advance && held_we && held_wr_idx == i[1:0]) begin
            held_ff[i] <= in_byte;
         end
      end
   end

   // A character in progress always has at least two bytes.
   a_len_not_one : assert property (@(posedge clock) disable iff (reset)
      char_len_ff != 3'd1)
      else $error("character length of one held");

   // Held bytes stay fewer than the character length.
   a_cnt_below_len : assert property (@(posedge clock) disable iff (reset)
      (char_len_ff != 3'd0) |-> (held_cnt_ff != 2'd0 && {1'b0, held_cnt_ff} < char_len_ff))
      else $error("held byte count out of range");

   // Encoding never leaves a partial character behind.
   a_encode_no_hold : assert property (@(posedge clock) disable iff (reset)
      (dir_ff == bluc_pkg::DIR_ENCODE) |-> (char_len_ff == 3'd0))
      else $error("partial character held while encoding");

endmodule

// ----- src/bluc_out_serializer.sv -----
// Result register that sends a group of result bytes one per cycle while rsp_ready is high.
module bluc_out_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  bluc_pkg::grp_type grp,
   output logic              load_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run,
   output logic              rsp_text_done
);

   logic [bluc_pkg::MaxResults-1:0][7:0] data_ff;
   logic [2:0]                           left_ff;
   logic                                 eot_ff;
   logic                                 take;

   assign rsp_valid       = (left_ff != 3'd0);
   assign take            = rsp_valid && rsp_ready;
   assign load_ready      = (left_ff == 3'd0) || (take && left_ff == 3'd1);
   assign rsp_out_byte    = data_ff[0];
   assign rsp_last_of_run = (left_ff == 3'd1);
   assign rsp_text_done   = (left_ff == 3'd1) && eot_ff;

   // Remaining result count.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 3'd0;
      end else if (load) begin
         left_ff <= grp.count;
      end else if (take) begin
         left_ff <= left_ff - 3'd1;
      end
   end

   // Result bytes shift toward the output as each one is taken.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= grp.bytes;
         eot_ff  <= grp.eot;
      end else if (take) begin
         data_ff <= {8'd0, data_ff[bluc_pkg::MaxResults-1:1]};
      end
   end

   // The count never exceeds one full group.
   a_left_max : assert property (@(posedge clock) disable iff (reset)
      left_ff <= 3'd4)
      else $error("result count above group size");

   // A new group never overwrites results still waiting.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      load |-> (left_ff == 3'd0 || (take && left_ff == 3'd1)))
      else $error("result group overwritten");

   // Every loaded group carries at least one result.
   a_load_nonempty : assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("empty result group loaded");

endmodule

// ----- src/byte_level_unicode_codec.sv -----
// Byte-level codec top level: input register, character unit and result serializer.
// Converts a byte stream between raw bytes and byte-level text; csr_wr_data sets the
// direction (0 encode, 1 decode), and a write drops any partial character, so write
// it only between texts. Each request is registered, turned into a group of zero to
// four result bytes and loaded into the result register, whose bytes leave one per
// cycle while rsp_ready is high. Encoding gives one result byte for bytes that stay
// ASCII and two for the rest; decoding gives none for a byte that is held, one
// for a single byte or a character mapped back, and up to four when a character
// passes through. A request can wait in the input register while earlier results leave.
module byte_level_unicode_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_text_done
);

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_eot_ff;
   logic              advance;
   logic              load_ready;
   logic              load;
   bluc_pkg::grp_type grp;

   // A request leaves the input register once its results fit in the serializer.
   assign advance   = in_valid_ff && (grp.count == 3'd0 || load_ready);
   assign load      = advance && (grp.count != 3'd0);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   bluc_char_unit u_char (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .in_byte     (in_byte_ff),
      .in_eot      (in_eot_ff),
      .grp         (grp)
   );

   bluc_out_serializer u_ser (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .grp             (grp),
      .load_ready      (load_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_text_done   (rsp_text_done)
   );

endmodule
